FILE: rtl/core/line_plane_intersection_assert.svh
// assertion macros for the rtl, clocked on clk with rst_n as reset
`ifndef LINE_PLANE_INTERSECTION_ASSERT_SVH
`define LINE_PLANE_INTERSECTION_ASSERT_SVH

// same-cycle implication
`define LPI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpi assertion failed");

// next-cycle implication
`define LPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpi assertion failed");

`endif

FILE: rtl/core/lpi_pkg.sv
package lpi_pkg;

    localparam int WORD_BITS_DEF   = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_INDEX_BITS  = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PLANE_A      = 2'd0,
        REG_PLANE_B      = 2'd1,
        REG_PLANE_C      = 2'd2,
        REG_PLANE_OFFSET = 2'd3
    } cfg_reg_t;

    // per-item control that travels with the payload
    typedef struct packed {
        logic valid;
        logic exists;
        logic par;
    } lpi_ctrl_t;

endpackage

FILE: rtl/core/line_plane_intersection.sv
// Line / plane intersection in signed fixed point (WORD_BITS wide, FRAC_BITS
// fraction). One item is taken per clock: start with busy low. Each result
// is shown for a single cycle with done high, in input order; the receiver
// cannot stall, so done must be taken when it comes. The quotient divider
// produces one quotient bit per pipeline stage (WORD_BITS + 1 stages), behind
// two front stages of dot products and three stages of product and overflow
// check. A short queue sits between the front and the back end; the back end
// drains it every cycle, so busy stays low in normal use. Plane registers are
// written through cfg_we / cfg_index / cfg_data and should only change while
// no item is in flight.
module line_plane_intersection #(
    parameter int WORD_BITS   = lpi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS   = lpi_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = lpi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // item transfer
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic signed [WORD_BITS-1:0]        origin_x,
    input  logic signed [WORD_BITS-1:0]        origin_y,
    input  logic signed [WORD_BITS-1:0]        origin_z,
    input  logic                               origin_valid,
    input  logic signed [WORD_BITS-1:0]        dir_x,
    input  logic signed [WORD_BITS-1:0]        dir_y,
    input  logic signed [WORD_BITS-1:0]        dir_z,
    // plane register writes
    input  logic                               cfg_we,
    input  logic [lpi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]               cfg_data,
    // result strobe
    output logic                               done,
    output logic signed [WORD_BITS-1:0]        hit_x,
    output logic signed [WORD_BITS-1:0]        hit_y,
    output logic signed [WORD_BITS-1:0]        hit_z,
    output logic                               hit_exists
);

    localparam int W = WORD_BITS;
    localparam int NUM_MAG_BITS =
        ((2 * W > W + FRAC_BITS) ? 2 * W : W + FRAC_BITS) + 1;
    // queue word: num mag, num sign, den mag, den sign, o, v, exists, par
    localparam int QDATA_BITS = NUM_MAG_BITS + 1 + 2 * W + 1 + 6 * W + 2;

    logic signed [W-1:0] plane_a_reg, plane_b_reg, plane_c_reg, plane_offset_reg;

    lpi_pkg::lpi_ctrl_t      f_ctrl;
    logic [NUM_MAG_BITS-1:0] f_num_mag;
    logic                    f_num_neg;
    logic [2*W-1:0]          f_den_mag;
    logic                    f_den_neg;
    logic signed [W-1:0]     f_ox, f_oy, f_oz, f_vx, f_vy, f_vz;

    logic [QDATA_BITS-1:0]   q_push_data, q_pop_data;
    logic                    q_full, q_pop_valid;

    lpi_pkg::lpi_ctrl_t      b_ctrl;
    logic [NUM_MAG_BITS-1:0] b_num_mag;
    logic                    b_num_neg;
    logic [2*W-1:0]          b_den_mag;
    logic                    b_den_neg;
    logic signed [W-1:0]     b_ox, b_oy, b_oz, b_vx, b_vy, b_vz;
    logic                    b_exists, b_par;

    // plane registers, c resets to 1.0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_a_reg      <= '0;
            plane_b_reg      <= '0;
            plane_c_reg      <= {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
            plane_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpi_pkg::REG_PLANE_A:      plane_a_reg      <= cfg_data;
                lpi_pkg::REG_PLANE_B:      plane_b_reg      <= cfg_data;
                lpi_pkg::REG_PLANE_C:      plane_c_reg      <= cfg_data;
                lpi_pkg::REG_PLANE_OFFSET: plane_offset_reg <= cfg_data;
                default:                   plane_a_reg      <= plane_a_reg;
            endcase
        end
    end

    // front end: dot products, numerator, denominator, parallel check
    lpi_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .cmd          (cmd),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .origin_z     (origin_z),
        .origin_valid (origin_valid),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .plane_a      (plane_a_reg),
        .plane_b      (plane_b_reg),
        .plane_c      (plane_c_reg),
        .plane_offset (plane_offset_reg),
        .out_ctrl     (f_ctrl),
        .out_num_mag  (f_num_mag),
        .out_num_neg  (f_num_neg),
        .out_den_mag  (f_den_mag),
        .out_den_neg  (f_den_neg),
        .out_ox       (f_ox),
        .out_oy       (f_oy),
        .out_oz       (f_oz),
        .out_vx       (f_vx),
        .out_vy       (f_vy),
        .out_vz       (f_vz)
    );

    assign q_push_data = {f_num_mag, f_num_neg, f_den_mag, f_den_neg,
                          f_ox, f_oy, f_oz, f_vx, f_vy, f_vz,
                          f_ctrl.exists, f_ctrl.par};

    // decoupling queue between front and back end
    lpi_queue #(
        .DATA_BITS (QDATA_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_ctrl.valid),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_pop_valid),
        .pop_data  (q_pop_data)
    );

    // stop new transfers only if the queue ever fills
    assign busy = q_full;

    assign {b_num_mag, b_num_neg, b_den_mag, b_den_neg,
            b_ox, b_oy, b_oz, b_vx, b_vy, b_vz, b_exists, b_par} = q_pop_data;

    always_comb
    begin
        b_ctrl.valid  = q_pop_valid;
        b_ctrl.exists = b_exists;
        b_ctrl.par    = b_par;
    end

    // back end: scaled product, bit-per-stage divide, origin add, saturate
    lpi_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctrl    (b_ctrl),
        .num_mag    (b_num_mag),
        .num_neg    (b_num_neg),
        .den_mag    (b_den_mag),
        .den_neg    (b_den_neg),
        .ox         (b_ox),
        .oy         (b_oy),
        .oz         (b_oz),
        .vx         (b_vx),
        .vy         (b_vy),
        .vz         (b_vz),
        .done       (done),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .hit_z      (hit_z),
        .hit_exists (hit_exists)
    );

endmodule

FILE: rtl/core/lpi_front.sv
module lpi_front #(
    parameter int WORD_BITS = lpi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = lpi_pkg::FRAC_BITS_DEF,
    localparam int NUM_MAG_BITS =
        ((2 * WORD_BITS > WORD_BITS + FRAC_BITS) ? 2 * WORD_BITS : WORD_BITS + FRAC_BITS) + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        cmd,
    input  logic signed [WORD_BITS-1:0] origin_x,
    input  logic signed [WORD_BITS-1:0] origin_y,
    input  logic signed [WORD_BITS-1:0] origin_z,
    input  logic                        origin_valid,
    input  logic signed [WORD_BITS-1:0] dir_x,
    input  logic signed [WORD_BITS-1:0] dir_y,
    input  logic signed [WORD_BITS-1:0] dir_z,
    input  logic signed [WORD_BITS-1:0] plane_a,
    input  logic signed [WORD_BITS-1:0] plane_b,
    input  logic signed [WORD_BITS-1:0] plane_c,
    input  logic signed [WORD_BITS-1:0] plane_offset,
    output lpi_pkg::lpi_ctrl_t          out_ctrl,
    output logic [NUM_MAG_BITS-1:0]     out_num_mag,
    output logic                        out_num_neg,
    output logic [2*WORD_BITS-1:0]      out_den_mag,
    output logic                        out_den_neg,
    output logic signed [WORD_BITS-1:0] out_ox,
    output logic signed [WORD_BITS-1:0] out_oy,
    output logic signed [WORD_BITS-1:0] out_oz,
    output logic signed [WORD_BITS-1:0] out_vx,
    output logic signed [WORD_BITS-1:0] out_vy,
    output logic signed [WORD_BITS-1:0] out_vz
);

    localparam int NUM_S = NUM_MAG_BITS + 1;
    localparam int DEN_S = 2 * WORD_BITS + 2;
    localparam int PW    = 2 * WORD_BITS;

    logic signed [WORD_BITS-1:0] vx_sel, vy_sel, vz_sel;

    logic                        f1_valid_reg, f1_exists_reg;
    logic signed [PW-1:0]        nv_x_reg, nv_y_reg, nv_z_reg;
    logic signed [PW-1:0]        no_x_reg, no_y_reg, no_z_reg;
    logic signed [WORD_BITS-1:0] f1_ox_reg, f1_oy_reg, f1_oz_reg;
    logic signed [WORD_BITS-1:0] f1_vx_reg, f1_vy_reg, f1_vz_reg;

    logic signed [DEN_S-1:0]     den_s;
    logic signed [NUM_S-1:0]     num_s;

    lpi_pkg::lpi_ctrl_t          ctrl_reg;
    logic [NUM_MAG_BITS-1:0]     num_mag_reg;
    logic                        num_neg_reg;
    logic [PW-1:0]               den_mag_reg;
    logic                        den_neg_reg;
    logic signed [WORD_BITS-1:0] ox_reg, oy_reg, oz_reg, vx_reg, vy_reg, vz_reg;

    // projection uses the plane normal as direction
    assign vx_sel = cmd ? plane_a : dir_x;
    assign vy_sel = cmd ? plane_b : dir_y;
    assign vz_sel = cmd ? plane_c : dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_exists_reg <= origin_valid;
        nv_x_reg      <= plane_a * vx_sel;
        nv_y_reg      <= plane_b * vy_sel;
        nv_z_reg      <= plane_c * vz_sel;
        no_x_reg      <= plane_a * origin_x;
        no_y_reg      <= plane_b * origin_y;
        no_z_reg      <= plane_c * origin_z;
        f1_ox_reg     <= origin_x;
        f1_oy_reg     <= origin_y;
        f1_oz_reg     <= origin_z;
        f1_vx_reg     <= vx_sel;
        f1_vy_reg     <= vy_sel;
        f1_vz_reg     <= vz_sel;
    end

    // den = n.v, num = -(d + n.o) at double fraction
    always_comb
    begin
        den_s = DEN_S'(nv_x_reg) + DEN_S'(nv_y_reg) + DEN_S'(nv_z_reg);
        num_s = -(NUM_S'(plane_offset) <<< FRAC_BITS)
                - NUM_S'(no_x_reg) - NUM_S'(no_y_reg) - NUM_S'(no_z_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg.valid  <= f1_valid_reg;
            ctrl_reg.exists <= f1_exists_reg;
            ctrl_reg.par    <= (den_s == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        num_neg_reg <= num_s[NUM_S-1];
        num_mag_reg <= num_s[NUM_S-1] ? NUM_MAG_BITS'(-num_s) : NUM_MAG_BITS'(num_s);
        den_neg_reg <= den_s[DEN_S-1];
        den_mag_reg <= den_s[DEN_S-1] ? PW'(-den_s) : PW'(den_s);
        ox_reg      <= f1_ox_reg;
        oy_reg      <= f1_oy_reg;
        oz_reg      <= f1_oz_reg;
        vx_reg      <= f1_vx_reg;
        vy_reg      <= f1_vy_reg;
        vz_reg      <= f1_vz_reg;
    end

    assign out_ctrl    = ctrl_reg;
    assign out_num_mag = num_mag_reg;
    assign out_num_neg = num_neg_reg;
    assign out_den_mag = den_mag_reg;
    assign out_den_neg = den_neg_reg;
    assign out_ox      = ox_reg;
    assign out_oy      = oy_reg;
    assign out_oz      = oz_reg;
    assign out_vx      = vx_reg;
    assign out_vy      = vy_reg;
    assign out_vz      = vz_reg;

endmodule

FILE: rtl/core/lpi_queue.sv
module lpi_queue #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = lpi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 full,
    output logic                 pop_valid,
    output logic [DATA_BITS-1:0] pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic                 pop;
    logic                 do_push;
    logic                 pop_valid_reg;
    logic [DATA_BITS-1:0] pop_data_reg;

    // the back end never stalls: drain whenever something is held
    assign pop     = (count_reg != '0);
    // a full queue is always popping, so the slot frees in the same cycle
    assign do_push = push && ((count_reg != CNT_BITS'(DEPTH)) || pop);
    assign full    = (count_reg == CNT_BITS'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            pop_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg     <= count_reg + CNT_BITS'(do_push) - CNT_BITS'(pop);
            pop_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop)
        begin
            pop_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign pop_valid = pop_valid_reg;
    assign pop_data  = pop_data_reg;

endmodule

FILE: rtl/core/lpi_back.sv
`include "line_plane_intersection_assert.svh"

module lpi_back #(
    parameter int WORD_BITS = lpi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = lpi_pkg::FRAC_BITS_DEF,
    localparam int NUM_MAG_BITS =
        ((2 * WORD_BITS > WORD_BITS + FRAC_BITS) ? 2 * WORD_BITS : WORD_BITS + FRAC_BITS) + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lpi_pkg::lpi_ctrl_t          in_ctrl,
    input  logic [NUM_MAG_BITS-1:0]     num_mag,
    input  logic                        num_neg,
    input  logic [2*WORD_BITS-1:0]      den_mag,
    input  logic                        den_neg,
    input  logic signed [WORD_BITS-1:0] ox,
    input  logic signed [WORD_BITS-1:0] oy,
    input  logic signed [WORD_BITS-1:0] oz,
    input  logic signed [WORD_BITS-1:0] vx,
    input  logic signed [WORD_BITS-1:0] vy,
    input  logic signed [WORD_BITS-1:0] vz,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] hit_x,
    output logic signed [WORD_BITS-1:0] hit_y,
    output logic signed [WORD_BITS-1:0] hit_z,
    output logic                        hit_exists
);

    localparam int W         = WORD_BITS;
    localparam int PW        = 2 * W;
    localparam int NCHUNK    = (NUM_MAG_BITS + W - 1) / W;
    localparam int PROD_BITS = W + NCHUNK * W;
    localparam int QB        = W + 1;
    localparam int SW        = W + 3;
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] o_in [3];
    logic signed [W-1:0] v_in [3];
    logic [NCHUNK*W-1:0] num_ext;

    // partial products
    lpi_pkg::lpi_ctrl_t  b1_ctrl_reg;
    logic [PW-1:0]       b1_den_reg;
    logic                b1_sign_reg [3];
    logic signed [W-1:0] b1_o_reg [3];
    logic [PW-1:0]       b1_pp_reg [3][NCHUNK];

    // full product |v|*|num|
    lpi_pkg::lpi_ctrl_t  b2_ctrl_reg;
    logic [PW-1:0]       b2_den_reg;
    logic                b2_sign_reg [3];
    logic signed [W-1:0] b2_o_reg [3];
    logic [PROD_BITS-1:0] b2_prod_reg [3];

    // divider stages, one quotient bit per stage
    lpi_pkg::lpi_ctrl_t  ctrl_reg [QB+1];
    logic [PW-1:0]       den_reg  [QB+1];
    logic [PW-1:0]       rem_reg  [QB+1][3];
    logic [QB-1:0]       low_reg  [QB+1][3];
    logic [QB-1:0]       q_reg    [QB+1][3];
    logic                sign_reg [QB+1][3];
    logic                ovf_reg  [QB+1][3];
    logic signed [W-1:0] o_reg    [QB+1][3];

    logic [W-1:0]        hit_next [3];

    logic                done_reg, exists_reg, par_out_reg;
    logic [2:0]          ovf_out_reg;
    logic signed [W-1:0] hit_reg [3];

    assign o_in[0] = ox;
    assign o_in[1] = oy;
    assign o_in[2] = oz;
    assign v_in[0] = vx;
    assign v_in[1] = vy;
    assign v_in[2] = vz;
    assign num_ext = (NCHUNK*W)'(num_mag);

    function automatic logic [PROD_BITS-1:0] sum_upper(input int lane);
        logic [PROD_BITS-1:0] acc;
        acc = '0;
        for (int k = 1; k < NCHUNK; k++)
        begin
            acc = acc + (PROD_BITS'(b1_pp_reg[lane][k]) << (k * W));
        end
        return acc;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_ctrl_reg <= '0;
            b2_ctrl_reg <= '0;
            ctrl_reg[0] <= '0;
        end
        else
        begin
            b1_ctrl_reg <= in_ctrl;
            b2_ctrl_reg <= b1_ctrl_reg;
            ctrl_reg[0] <= b2_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_den_reg <= den_mag;
        b2_den_reg <= b1_den_reg;
        den_reg[0] <= b2_den_reg;
        for (int i = 0; i < 3; i++)
        begin
            b1_sign_reg[i] <= v_in[i][W-1] ^ num_neg ^ den_neg;
            b1_o_reg[i]    <= o_in[i];
            for (int k = 0; k < NCHUNK; k++)
            begin
                b1_pp_reg[i][k] <= PW'($unsigned(v_in[i][W-1] ? -v_in[i] : v_in[i]))
                                   * PW'(num_ext[k*W +: W]);
            end
            b2_sign_reg[i] <= b1_sign_reg[i];
            b2_o_reg[i]    <= b1_o_reg[i];
        end
        // sum of shifted partial products
        for (int i = 0; i < 3; i++)
        begin
            b2_prod_reg[i] <= PROD_BITS'(b1_pp_reg[i][0])
                              + sum_upper(i);
        end
        // overflow check and initial remainder
        for (int i = 0; i < 3; i++)
        begin
            ovf_reg[0][i]  <= (b2_prod_reg[i] >> QB) >= PROD_BITS'(b2_den_reg);
            rem_reg[0][i]  <= b2_prod_reg[i][QB +: PW];
            low_reg[0][i]  <= b2_prod_reg[i][QB-1:0];
            q_reg[0][i]    <= '0;
            sign_reg[0][i] <= b2_sign_reg[i];
            o_reg[0][i]    <= b2_o_reg[i];
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_div
        logic [PW:0] rem2 [3];
        logic        ge   [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem2[i] = {rem_reg[s][i], low_reg[s][i][QB-1]};
                ge[i]   = rem2[i] >= {1'b0, den_reg[s]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[s+1] <= '0;
            end
            else
            begin
                ctrl_reg[s+1] <= ctrl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[s+1] <= den_reg[s];
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[s+1][i]  <= ge[i] ? PW'(rem2[i] - {1'b0, den_reg[s]}) : PW'(rem2[i]);
                low_reg[s+1][i]  <= low_reg[s][i] << 1;
                q_reg[s+1][i]    <= {q_reg[s][i][QB-2:0], ge[i]};
                sign_reg[s+1][i] <= sign_reg[s][i];
                ovf_reg[s+1][i]  <= ovf_reg[s][i];
                o_reg[s+1][i]    <= o_reg[s][i];
            end
        end
    end

    // add origin, saturate to the word, zero for a parallel line
    always_comb
    begin
        logic [QB-1:0]        qmag;
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            qmag = ovf_reg[QB][i] ? '1 : q_reg[QB][i];
            qs   = sign_reg[QB][i] ? -$signed(SW'(qmag)) : $signed(SW'(qmag));
            sum  = SW'(o_reg[QB][i]) + qs;
            if (sum[SW-1:W-1] == '0 || sum[SW-1:W-1] == '1)
            begin
                hit_next[i] = sum[W-1:0];
            end
            else
            begin
                hit_next[i] = sum[SW-1] ? SAT_MIN : SAT_MAX;
            end
            if (ctrl_reg[QB].par)
            begin
                hit_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_reg[QB].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        exists_reg  <= ctrl_reg[QB].exists && !ctrl_reg[QB].par;
        par_out_reg <= ctrl_reg[QB].par;
        for (int i = 0; i < 3; i++)
        begin
            hit_reg[i]     <= hit_next[i];
            ovf_out_reg[i] <= ovf_reg[QB][i];
        end
    end

    assign done       = done_reg;
    assign hit_x      = hit_reg[0];
    assign hit_y      = hit_reg[1];
    assign hit_z      = hit_reg[2];
    assign hit_exists = exists_reg;

    `LPI_ASSERT_NEXT(a_div_to_out, ctrl_reg[QB].valid, done_reg)
    `LPI_ASSERT_IMPL(a_par_zero, done_reg && par_out_reg, hit_reg[0] == '0 && hit_reg[1] == '0 && hit_reg[2] == '0 && !exists_reg)
    `LPI_ASSERT_IMPL(a_ovf_sat, done_reg && ovf_out_reg[0] && !par_out_reg, hit_reg[0] == SAT_MAX || hit_reg[0] == SAT_MIN)

endmodule

FILE: dv/line_plane_intersection_checker.sv
`timescale 1ns / 1ps

module line_plane_intersection_checker
    import lpi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      cmd,
    input  logic signed [WORD_BITS_DEF-1:0] origin_x,
    input  logic signed [WORD_BITS_DEF-1:0] origin_y,
    input  logic signed [WORD_BITS_DEF-1:0] origin_z,
    input  logic                      origin_valid,
    input  logic signed [WORD_BITS_DEF-1:0] dir_x,
    input  logic signed [WORD_BITS_DEF-1:0] dir_y,
    input  logic signed [WORD_BITS_DEF-1:0] dir_z,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS_DEF-1:0]  cfg_data,
    input  logic                      done,
    input  logic signed [WORD_BITS_DEF-1:0] hit_x,
    input  logic signed [WORD_BITS_DEF-1:0] hit_y,
    input  logic signed [WORD_BITS_DEF-1:0] hit_z,
    input  logic                      hit_exists,
    output int                        fail_count,
    output int                        pending
);
    localparam int W = WORD_BITS_DEF;
    localparam int F = FRAC_BITS_DEF;

    typedef logic signed [W-1:0]  word_t;
    typedef logic signed [191:0]  wide_t;

    typedef struct {
        word_t x;
        word_t y;
        word_t z;
        logic  exists;
    } hit_t;

    word_t plane_a, plane_b, plane_c, plane_offset;
    hit_t  expected_hits[$];

    assign pending = expected_hits.size();

    function automatic word_t clamp_word(wide_t s);
        wide_t hi, lo;
        hi = (wide_t'(1) <<< (W - 1)) - 1;
        lo = -(wide_t'(1) <<< (W - 1));
        if (s > hi) return word_t'(hi);
        if (s < lo) return word_t'(lo);
        return word_t'(s);
    endfunction

    function automatic hit_t intersect_plane(logic op, word_t ox, word_t oy, word_t oz,
                                             logic ov, word_t dx, word_t dy, word_t dz);
        wide_t na, nb, nc, d, o0, o1, o2, v0, v1, v2, num, den;
        hit_t  h;
        na = plane_a; nb = plane_b; nc = plane_c; d = plane_offset;
        o0 = ox; o1 = oy; o2 = oz;
        if (op) begin
            v0 = na; v1 = nb; v2 = nc;
        end
        else begin
            v0 = dx; v1 = dy; v2 = dz;
        end
        den = na * v0 + nb * v1 + nc * v2;
        num = -((d <<< F) + na * o0 + nb * o1 + nc * o2);
        if (den == 0) begin
            h.x = '0; h.y = '0; h.z = '0; h.exists = 1'b0;
        end
        else begin
            // signed division truncates toward zero
            h.x = clamp_word(o0 + (v0 * num) / den);
            h.y = clamp_word(o1 + (v1 * num) / den);
            h.z = clamp_word(o2 + (v2 * num) / den);
            h.exists = ov;
        end
        return h;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        hit_t e;
        if (!rst_n) begin
            plane_a      <= '0;
            plane_b      <= '0;
            plane_c      <= word_t'(1) <<< F;
            plane_offset <= '0;
            expected_hits.delete();
            fail_count   <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_PLANE_A:      plane_a      <= cfg_data;
                    REG_PLANE_B:      plane_b      <= cfg_data;
                    REG_PLANE_C:      plane_c      <= cfg_data;
                    REG_PLANE_OFFSET: plane_offset <= cfg_data;
                    default: ;
                endcase
            end
            if (done) begin
                if (expected_hits.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %h %h %h %b",
                                 hit_x, hit_y, hit_z, hit_exists);
                    fail_count <= fail_count + 1;
                end
                else begin
                    e = expected_hits.pop_front();
                    if (e.x !== hit_x || e.y !== hit_y || e.z !== hit_z ||
                        e.exists !== hit_exists) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h %h %h %b got %h %h %h %b",
                                     e.x, e.y, e.z, e.exists,
                                     hit_x, hit_y, hit_z, hit_exists);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_hits.push_back(intersect_plane(cmd, origin_x, origin_y, origin_z,
                                                        origin_valid, dir_x, dir_y, dir_z));
        end
    end
endmodule

FILE: dv/line_plane_intersection_test.sv
`timescale 1ns / 1ps

module line_plane_intersection_test;
    import lpi_pkg::*;

    localparam int W = WORD_BITS_DEF;
    localparam int F = FRAC_BITS_DEF;
    // margin for draining the pipeline after the last result
    localparam int LATENCY = W + 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [W-1:0] word_t;

    localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};
    localparam word_t ONE  = word_t'(1) <<< F;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = 1'b0;
    word_t       origin_x = '0, origin_y = '0, origin_z = '0;
    logic        origin_valid = 1'b0;
    word_t       dir_x = '0, dir_y = '0, dir_z = '0;
    logic        cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [W-1:0] cfg_data = '0;
    logic        done;
    word_t       hit_x, hit_y, hit_z;
    logic        hit_exists;
    int          fail_count, pending;
    int          cycles = 0;

    always #5 clk = ~clk;

    line_plane_intersection dut (.*);

    line_plane_intersection_checker checker_i (.*);

    // run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("line_plane_intersection_test NOT OK");
            $finish;
        end
    end

    // mostly small coordinates so the hit is meaningful, plus full range and extremes
    function automatic word_t pick_coord();
        word_t r;
        case ($urandom_range(0, 9))
            0, 1:    r = $urandom;
            2:       r = $urandom_range(0, 1) ? WMAX : WMIN;
            3:       r = '0;
            default:
            begin
                r = word_t'($urandom_range(0, 1 << 22));
                if ($urandom_range(0, 1)) r = -r;
            end
        endcase
        return r;
    endfunction

    task automatic idle_gap();
        int n;
        // mostly back to back or short, now and then a long pause
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = 0;
            9:          n = $urandom_range(10, 40);
            default:    n = $urandom_range(1, 3);
        endcase
        if (n > 0)
        begin
            start = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // one transfer: present at the falling edge, hold until busy is seen low
    task automatic send_item(logic op, word_t ox, word_t oy, word_t oz, logic ov,
                             word_t dx, word_t dy, word_t dz);
        logic taken;
        start = 1'b1;
        cmd = op;
        origin_x = ox; origin_y = oy; origin_z = oz;
        origin_valid = ov;
        dir_x = dx; dir_y = dy; dir_z = dz;
        taken = 1'b0;
        while (!taken)
        begin
            taken = !busy;
            @(negedge clk);
        end
    endtask

    task automatic send_random();
        word_t dx, dy, dz;
        dx = pick_coord(); dy = pick_coord(); dz = pick_coord();
        // some lines lying in the plane's direction space to hit the parallel case
        if ($urandom_range(0, 11) == 0)
        begin
            dx = '0; dy = '0; dz = '0;
        end
        send_item($urandom_range(0, 3) == 0, pick_coord(), pick_coord(), pick_coord(),
                  1'($urandom_range(0, 1)), dx, dy, dz);
        idle_gap();
    endtask

    // wait for the pipeline to empty before touching the plane
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic set_plane(word_t a, word_t b, word_t c, word_t d);
        cfg_we = 1'b1;
        cfg_index = REG_PLANE_A;      cfg_data = a; @(negedge clk);
        cfg_index = REG_PLANE_B;      cfg_data = b; @(negedge clk);
        cfg_index = REG_PLANE_C;      cfg_data = c; @(negedge clk);
        cfg_index = REG_PLANE_OFFSET; cfg_data = d; @(negedge clk);
        cfg_we = 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset plane is z = 0
        send_item(1'b0, ONE, 2 * ONE, 3 * ONE, 1'b1, '0, '0, -ONE);
        send_item(1'b0, ONE, 2 * ONE, 3 * ONE, 1'b0, ONE, ONE, ONE);
        // parallel line
        send_item(1'b0, ONE, ONE, ONE, 1'b1, ONE, -ONE, '0);
        send_item(1'b0, '0, '0, '0, 1'b1, '0, '0, '0);
        // point projection
        send_item(1'b1, 5 * ONE, -7 * ONE, 9 * ONE, 1'b1, WMAX, WMAX, WMAX);
        send_item(1'b1, WMIN, WMAX, WMIN, 1'b0, '0, '0, '0);
        // extremes and saturation
        send_item(1'b0, WMAX, WMAX, WMAX, 1'b1, WMAX, WMIN, 1);
        send_item(1'b0, WMIN, WMIN, WMIN, 1'b1, WMIN, WMAX, -1);
        send_item(1'b0, WMAX, WMIN, WMAX, 1'b1, WMIN, WMIN, WMIN);
        send_item(1'b0, 1, -1, WMAX, 1'b1, 1, 1, WMAX);
        send_item(1'b1, -1, -1, -1, 1'b1, -1, -1, -1);
        drain();

        // degenerate plane: projection is always parallel
        set_plane('0, '0, '0, ONE);
        send_item(1'b1, ONE, ONE, ONE, 1'b1, '0, '0, '0);
        send_item(1'b0, ONE, ONE, ONE, 1'b1, ONE, ONE, ONE);
        repeat (40) send_random();
        drain();

        // largest coefficients
        set_plane(WMAX, WMAX, WMAX, WMAX);
        send_item(1'b1, WMIN, WMIN, WMIN, 1'b1, '0, '0, '0);
        repeat (60) send_random();
        drain();

        set_plane(WMIN, WMIN, WMIN, WMIN);
        send_item(1'b1, WMAX, WMAX, WMAX, 1'b1, '0, '0, '0);
        repeat (60) send_random();
        drain();

        // tilted unit-scale plane
        set_plane(ONE, -2 * ONE, ONE / 2, -3 * ONE);
        repeat (80) send_random();
        drain();

        // random planes, coefficients mostly small
        repeat (4)
        begin
            set_plane(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            repeat (40) send_random();
            drain();
        end

        if (fail_count == 0)
            $display("line_plane_intersection_test OK");
        else
            $display("line_plane_intersection_test NOT OK");
        $finish;
    end
endmodule
